// ===== hdl/pzv_pkg.sv =====
package pzv_pkg;

	// Default polygon capacity, handed to the top level as a parameter default.
	localparam int MAX_VERTICES_DEF = 8;

	// Field widths.
	localparam int COORD_W  = 16;
	localparam int DIF_W    = COORD_W + 1;
	localparam int PRD_W    = 2 * DIF_W;
	localparam int STATUS_W = 3;
	localparam int CFG_IDX_W = 1;

	// A polygon needs three vertices; the edge-pair walk only runs from four on.
	localparam int MIN_VERTICES       = 3;
	localparam int CROSS_MIN_VERTICES = 4;

	// Four cross products are formed for each edge pair.
	localparam int NCROSS = 4;
	localparam int K_W    = 2;

	// Reset values of the range registers.
	localparam logic signed [COORD_W-1:0] COORD_MIN_RST = 16'sh8000;
	localparam logic signed [COORD_W-1:0] COORD_MAX_RST = 16'sh7FFF;

	// Result codes.
	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 3'd0,
		ST_TOO_FEW  = 3'd1,
		ST_TOO_MANY = 3'd2,
		ST_RANGE    = 3'd3,
		ST_CROSS    = 3'd4
	} status_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_COORD = 1'b0,
		REG_MAX_COORD = 1'b1
	} cfg_reg_t;

	// One stored vertex.
	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
	} vtx_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic wr_vertex;
		logic clear;
		logic walk_init;
		logic walk_next;
		logic rd_ab;
		logic rd_cd;
		logic mul;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic too_few;
		logic too_many;
		logic range_fault;
		logic no_walk;
		logic k_last;
		logic last_pair;
		logic pair_cross;
	} dp_sts_t;

endpackage

// ===== hdl/polygon_zone_validator_core.sv =====
// Polygon zone validator. Vertices arrive one per transfer as signed millimeter
// coordinates, one per cycle while the block loads, with last_vertex on the final
// one; up to MAX_VERTICES are stored, further ones are dropped. One status follows
// the last vertex: too few (under 3), too many, any stored vertex outside
// [min_coord_mm, max_coord_mm], self-intersecting, or ok. The self-intersection
// test steps through the edge pairs (i, j) with j at least i+2, which
// are the n*(n-3)/2 non-adjacent pairs plus the adjacent pair of the first and last
// edge, whose outcome is ignored. It uses one vertex store with two read ports and
// one shared product unit that forms one cross product a cycle, so each pair takes
// two store reads, four cross products, a last sign compare and a decision.
// A polygon passes through loading, evaluation, the edge pair walk (none when a
// count or range fault decides or under four vertices are stored) and the load
// of the output register.
// The walk stops at the first crossing pair. The next polygon's vertices are
// taken while the previous result still waits for its transfer.
module polygon_zone_validator_core import pzv_pkg::*; #(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [COORD_W-1:0]  vertex_x,
	input  logic signed [COORD_W-1:0]  vertex_y,
	input  logic                       last_vertex,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [STATUS_W-1:0]        status,
	output logic                       is_valid,
	input  logic                       cfg_we,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [COORD_W-1:0]         cfg_data
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	// Sequencing of loading, edge pair walk and result.
	pzv_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.last_vertex (last_vertex),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.is_valid    (is_valid),
		.cmd         (cmd),
		.sts         (sts)
	);

	// Vertex store, range check and cross product unit.
	pzv_datapath #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.vertex_x  (vertex_x),
		.vertex_y  (vertex_y),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule

// ===== hdl/pzv_datapath.sv =====
module pzv_datapath import pzv_pkg::*; #(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  dp_cmd_t                    cmd,
	output dp_sts_t                    sts,
	input  logic signed [COORD_W-1:0]  vertex_x,
	input  logic signed [COORD_W-1:0]  vertex_y,
	input  logic                       cfg_we,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [COORD_W-1:0]         cfg_data
);

	localparam int CNT_W = $clog2(MAX_VERTICES + 2);
	localparam int IDX_W = $clog2(MAX_VERTICES);
	localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(MAX_VERTICES);
	localparam logic [CNT_W-1:0] CNT_OVER  = CNT_W'(MAX_VERTICES + 1);
	localparam logic [CNT_W-1:0] CNT_MIN   = CNT_W'(MIN_VERTICES);
	localparam logic [CNT_W-1:0] CNT_CROSS = CNT_W'(CROSS_MIN_VERTICES);

	logic signed [COORD_W-1:0] min_q, max_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      range_q;
	logic                      oor;
	logic                      room;

	vtx_t                      mem [MAX_VERTICES];
	vtx_t                      rd0_q, rd1_q;
	vtx_t                      a_q, b_q;
	logic [IDX_W-1:0]          addr0, addr1;

	logic [CNT_W-1:0]          i_q, j_q;
	logic [CNT_W-1:0]          n_m1;
	logic [CNT_W-1:0]          i_nx, j_nx;
	logic [CNT_W:0]            i_p3;
	logic                      skip;

	logic [K_W-1:0]            k_q;
	vtx_t                      op_a, op_b, op_p;
	logic signed [DIF_W-1:0]   dbx, dby, dpx, dpy;
	logic signed [PRD_W-1:0]   p1, p2;
	logic signed [PRD_W-1:0]   p1_s1, p2_s1;
	logic [K_W-1:0]            k_s1;
	logic                      pv_s1;
	logic [NCROSS-1:0]         pos_q, neg_q;

	// Range registers, to be written only while the block is idle; the block does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= COORD_MIN_RST;
			max_q <= COORD_MAX_RST;
		end else if (cfg_we) begin
			if (cfg_index == REG_MIN_COORD) begin
				min_q <= cfg_data;
			end else begin
				max_q <= cfg_data;
			end
		end
	end

	// Range check of the incoming vertex against the registers as they stand.
	assign oor  = (vertex_x < min_q) || (vertex_x > max_q) ||
	              (vertex_y < min_q) || (vertex_y > max_q);
	assign room = (cnt_q < CNT_MAX);

	// Vertex count saturates one above capacity; the range fault is sticky.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			range_q <= 1'b0;
		end else if (cmd.clear) begin
			cnt_q   <= '0;
			range_q <= 1'b0;
		end else if (cmd.wr_vertex) begin
			if (room) begin
				cnt_q   <= cnt_q + CNT_W'(1);
				range_q <= range_q | oor;
			end else begin
				cnt_q <= CNT_OVER;
			end
		end
	end

	// Vertex store: one write port, two registered read ports.
	always_ff @(posedge clk) begin
		if (cmd.wr_vertex && room) begin
			mem[cnt_q[IDX_W-1:0]] <= '{x: vertex_x, y: vertex_y};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_ab || cmd.rd_cd) begin
			rd0_q <= mem[addr0];
			rd1_q <= mem[addr1];
		end
	end

	// Edge pair walk: edge i runs from vertex i to i+1, edge j from j to j+1, modulo n.
	assign n_m1  = cnt_q - CNT_W'(1);
	assign i_nx  = (i_q == n_m1) ? '0 : i_q + CNT_W'(1);
	assign j_nx  = (j_q == n_m1) ? '0 : j_q + CNT_W'(1);
	assign i_p3  = {1'b0, i_q} + (CNT_W + 1)'(3);
	assign skip  = (i_q == '0) && (j_q == n_m1);
	assign addr0 = cmd.rd_ab ? i_q[IDX_W-1:0]  : j_q[IDX_W-1:0];
	assign addr1 = cmd.rd_ab ? i_nx[IDX_W-1:0] : j_nx[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
			j_q <= '0;
		end else if (cmd.walk_init) begin
			i_q <= '0;
			j_q <= CNT_W'(2);
		end else if (cmd.walk_next) begin
			if (j_q == n_m1) begin
				i_q <= i_q + CNT_W'(1);
				j_q <= i_p3[CNT_W-1:0];
			end else begin
				j_q <= j_q + CNT_W'(1);
			end
		end
	end

	// The first edge is captured while the second is being read.
	always_ff @(posedge clk) begin
		if (cmd.rd_cd) begin
			a_q <= rd0_q;
			b_q <= rd1_q;
		end
	end

	// Cross product index, one product pair per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
		end else if (cmd.rd_cd) begin
			k_q <= '0;
		end else if (cmd.mul) begin
			k_q <= k_q + K_W'(1);
		end
	end

	// Operand selection: the two points of one edge against a point of the other.
	always_comb begin
		unique case (k_q)
			2'd0: begin
				op_a = rd0_q; op_b = rd1_q; op_p = a_q;
			end
			2'd1: begin
				op_a = rd0_q; op_b = rd1_q; op_p = b_q;
			end
			2'd2: begin
				op_a = a_q; op_b = b_q; op_p = rd0_q;
			end
			default: begin
				op_a = a_q; op_b = b_q; op_p = rd1_q;
			end
		endcase
	end

	// Differences and the two products of one cross product.
	assign dbx = DIF_W'(op_b.x) - DIF_W'(op_a.x);
	assign dby = DIF_W'(op_b.y) - DIF_W'(op_a.y);
	assign dpx = DIF_W'(op_p.x) - DIF_W'(op_a.x);
	assign dpy = DIF_W'(op_p.y) - DIF_W'(op_a.y);
	assign p1  = dbx * dpy;
	assign p2  = dby * dpx;

	always_ff @(posedge clk) begin
		p1_s1 <= p1;
		p2_s1 <= p2;
		k_s1  <= k_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_s1 <= 1'b0;
		end else begin
			pv_s1 <= cmd.mul;
		end
	end

	// The sign of each cross product comes from comparing its two products.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			neg_q <= '0;
		end else if (pv_s1) begin
			pos_q[k_s1] <= (p1_s1 > p2_s1);
			neg_q[k_s1] <= (p1_s1 < p2_s1);
		end
	end

	// Status toward the controller.
	always_comb begin
		sts.too_few     = (cnt_q < CNT_MIN);
		sts.too_many    = (cnt_q > CNT_MAX);
		sts.range_fault = range_q;
		sts.no_walk     = (cnt_q < CNT_CROSS);
		sts.k_last      = (k_q == K_W'(NCROSS - 1));
		sts.last_pair   = (j_q == n_m1) && (i_p3 >= {1'b0, cnt_q});
		sts.pair_cross  = !skip &&
		                  ((pos_q[0] && neg_q[1]) || (neg_q[0] && pos_q[1])) &&
		                  ((pos_q[2] && neg_q[3]) || (neg_q[2] && pos_q[3]));
	end

endmodule

// ===== hdl/pzv_ctrl.sv =====
module pzv_ctrl import pzv_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                last_vertex,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [STATUS_W-1:0] status,
	output logic                is_valid,
	output dp_cmd_t             cmd,
	input  dp_sts_t             sts
);

	typedef enum logic [7:0] {
		S_LOAD   = 8'b0000_0001,
		S_EVAL   = 8'b0000_0010,
		S_RD_AB  = 8'b0000_0100,
		S_RD_CD  = 8'b0000_1000,
		S_MUL    = 8'b0001_0000,
		S_CMP    = 8'b0010_0000,
		S_NEXT   = 8'b0100_0000,
		S_REPORT = 8'b1000_0000
	} state_t;

	state_t  st_q, st_d;
	status_t res_q, res_d;
	status_t out_status_q;
	logic    out_valid_q;
	logic    out_free;
	logic    in_xfer;

	assign in_ready = (st_q == S_LOAD);
	assign in_xfer  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// Next state, pending result and datapath commands.
	always_comb begin
		st_d  = st_q;
		res_d = res_q;
		cmd   = '0;
		unique case (st_q)
			S_LOAD: begin
				cmd.wr_vertex = in_xfer;
				if (in_xfer && last_vertex) begin
					st_d = S_EVAL;
				end
			end
			S_EVAL: begin
				st_d = S_REPORT;
				priority if (sts.too_few) begin
					res_d = ST_TOO_FEW;
				end else if (sts.too_many) begin
					res_d = ST_TOO_MANY;
				end else if (sts.range_fault) begin
					res_d = ST_RANGE;
				end else if (sts.no_walk) begin
					res_d = ST_OK;
				end else begin
					cmd.walk_init = 1'b1;
					st_d          = S_RD_AB;
				end
			end
			S_RD_AB: begin
				cmd.rd_ab = 1'b1;
				st_d      = S_RD_CD;
			end
			S_RD_CD: begin
				cmd.rd_cd = 1'b1;
				st_d      = S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				if (sts.k_last) begin
					st_d = S_CMP;
				end
			end
			S_CMP: begin
				st_d = S_NEXT;
			end
			S_NEXT: begin
				priority if (sts.pair_cross) begin
					res_d = ST_CROSS;
					st_d  = S_REPORT;
				end else if (sts.last_pair) begin
					res_d = ST_OK;
					st_d  = S_REPORT;
				end else begin
					cmd.walk_next = 1'b1;
					st_d          = S_RD_AB;
				end
			end
			S_REPORT: begin
				if (out_free) begin
					cmd.clear = 1'b1;
					st_d      = S_LOAD;
				end
			end
			default: begin
				st_d = S_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= S_LOAD;
			res_q <= ST_OK;
		end else begin
			st_q  <= st_d;
			res_q <= res_d;
		end
	end

	// Output register: the result waits here while the next polygon loads.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			out_status_q <= ST_OK;
		end else if (st_q == S_REPORT && out_free) begin
			out_valid_q  <= 1'b1;
			out_status_q <= res_q;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = out_status_q;
	assign is_valid  = (out_status_q == ST_OK);

`ifndef ASSERT_OFF
	// The final vertex always starts the evaluation.
	a_last_evals: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && last_vertex) |=> (st_q == S_EVAL))
		else $error("last vertex did not start evaluation");

	// A crossing pair ends the walk with the crossing code.
	a_cross_reports: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_NEXT && sts.pair_cross) |=> (st_q == S_REPORT && res_q == ST_CROSS))
		else $error("crossing pair not reported");

	// A free output register takes the pending result in the next cycle.
	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_REPORT && out_free) |=> (out_valid && status == $past(res_q)))
		else $error("pending result not transferred to output register");
`endif

endmodule

// ===== dv/tb_polygon_zone_validator_core.sv =====
module tb_polygon_zone_validator_core;
	timeunit 1ns;
	timeprecision 1ps;

	import pzv_pkg::*;

	localparam int MAXV           = MAX_VERTICES_DEF;
	localparam int WATCH_LIMIT    = 4000;
	localparam int DRAIN_CYCLES   = 200;
	localparam int SETTLE_CYCLES  = 4;
	localparam int PHASE_VERTICES = 185;
	localparam int SEND_GAP_MAX   = 40;
	localparam int RECV_STALL_MAX = 60;

	// Tracks the polygon under construction and the statuses still owed by the block.
	class polygon_scoreboard;
		logic signed [COORD_W-1:0] lo_mm;
		logic signed [COORD_W-1:0] hi_mm;
		logic signed [COORD_W-1:0] xs [MAXV];
		logic signed [COORD_W-1:0] ys [MAXV];
		int unsigned stored;
		bit range_bad;
		status_t status_q [$];
		int errors;
		int vertices;
		int results;
		int per_status [5];

		function new();
			lo_mm = COORD_MIN_RST;
			hi_mm = COORD_MAX_RST;
			stored = 0;
			range_bad = 1'b0;
			errors = 0;
			vertices = 0;
			results = 0;
			foreach (per_status[k]) per_status[k] = 0;
		endfunction

		function void set_range(cfg_reg_t idx, logic [COORD_W-1:0] v);
			if (idx == REG_MIN_COORD) begin
				lo_mm = v;
			end else begin
				hi_mm = v;
			end
		endfunction

		// Doubled signed area of triangle a, b, p; 64 bits keep it exact.
		function longint side(int ax, int ay, int bx, int by, int px, int py);
			return longint'(bx - ax) * longint'(py - ay) - longint'(by - ay) * longint'(px - ax);
		endfunction

		function bit strict_opposite(longint a, longint b);
			return (a > 0 && b < 0) || (a < 0 && b > 0);
		endfunction

		// Edges a-b and c-d cross only when each strictly straddles the other.
		function bit segments_cross(int a, int b, int c, int d);
			longint d1, d2, d3, d4;
			d1 = side(xs[c], ys[c], xs[d], ys[d], xs[a], ys[a]);
			d2 = side(xs[c], ys[c], xs[d], ys[d], xs[b], ys[b]);
			d3 = side(xs[a], ys[a], xs[b], ys[b], xs[c], ys[c]);
			d4 = side(xs[a], ys[a], xs[b], ys[b], xs[d], ys[d]);
			return strict_opposite(d1, d2) && strict_opposite(d3, d4);
		endfunction

		// Walks every pair of non-adjacent edges; triangles never cross.
		function bit has_crossing(int n);
			int i, j;
			if (n < CROSS_MIN_VERTICES || n > MAXV) return 1'b0;
			for (i = 0; i < n; i++) begin
				for (j = i + 2; j < n; j++) begin
					if (i == 0 && j == n - 1) continue;
					if (segments_cross(i, (i + 1) % n, j, (j + 1) % n)) return 1'b1;
				end
			end
			return 1'b0;
		endfunction

		// Stores one accepted vertex and, on the closing one, queues the status.
		function void note_vertex(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
				logic last);
			status_t st;
			vertices++;
			if (stored < MAXV) begin
				xs[stored] = x;
				ys[stored] = y;
				if (x < lo_mm || x > hi_mm || y < lo_mm || y > hi_mm) range_bad = 1'b1;
				stored++;
			end else begin
				stored = MAXV + 1;
			end
			if (!last) return;
			if (stored < MIN_VERTICES) begin
				st = ST_TOO_FEW;
			end else if (stored > MAXV) begin
				st = ST_TOO_MANY;
			end else if (range_bad) begin
				st = ST_RANGE;
			end else if (has_crossing(stored)) begin
				st = ST_CROSS;
			end else begin
				st = ST_OK;
			end
			status_q.push_back(st);
			stored = 0;
			range_bad = 1'b0;
		endfunction

		// Compares one result transfer with the oldest owed status.
		function void check_result(logic [STATUS_W-1:0] st, logic ok);
			status_t exp_st;
			logic exp_ok;
			if (status_q.size() == 0) begin
				$display("%0t: result with no polygon pending, status %0d is_valid %0b",
					$time, st, ok);
				errors++;
				return;
			end
			exp_st = status_q.pop_front();
			exp_ok = (exp_st == ST_OK);
			results++;
			per_status[int'(exp_st)]++;
			if (st !== exp_st) begin
				$display("%0t: status expected %0d, actual %0d", $time, exp_st, st);
				errors++;
			end
			if (ok !== exp_ok) begin
				$display("%0t: is_valid expected %0b, actual %0b", $time, exp_ok, ok);
				errors++;
			end
		endfunction

		function int pending();
			return status_q.size();
		endfunction
	endclass

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_ready;
	logic signed [COORD_W-1:0] vertex_x;
	logic signed [COORD_W-1:0] vertex_y;
	logic                      last_vertex;
	logic                      out_valid;
	logic                      out_ready;
	logic [STATUS_W-1:0]       status;
	logic                      is_valid;
	logic                      cfg_we;
	logic [CFG_IDX_W-1:0]      cfg_index;
	logic [COORD_W-1:0]        cfg_data;

	polygon_scoreboard sb;
	bit calm;
	int out_stall;
	int idle_cycles;
	int range_settings;

	polygon_zone_validator_core #(
		.MAX_VERTICES(MAXV)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.vertex_x(vertex_x),
		.vertex_y(vertex_y),
		.last_vertex(last_vertex),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.is_valid(is_valid),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Idle length: mostly none or short, now and then long; none in a calm stretch.
	function automatic int pick_gap(int longest);
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(longest / 2, longest);
	endfunction

	function automatic int coord_in(int lo, int hi);
		if (lo > hi) return int'($urandom_range(0, 65535)) - 32768;
		return lo + int'($urandom_range(0, hi - lo));
	endfunction

	function automatic int extreme(int lo, int hi);
		case ($urandom_range(0, 4))
			0: return lo;
			1: return hi;
			2: return -32768;
			3: return 32767;
			default: return 0;
		endcase
	endfunction

	// Mostly legal sizes, with some too short and some too long.
	function automatic int pick_count();
		int r;
		r = $urandom_range(0, 99);
		if (r < 6) return $urandom_range(1, 2);
		if (r < 14) return $urandom_range(MAXV + 1, MAXV + 4);
		return $urandom_range(MIN_VERTICES, MAXV);
	endfunction

	// Offers one vertex and holds it until the transfer.
	task automatic send_vertex(int x, int y, bit last);
		int gap;
		gap = pick_gap(SEND_GAP_MAX);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		vertex_x <= x[COORD_W-1:0];
		vertex_y <= y[COORD_W-1:0];
		last_vertex <= last;
		do @(posedge clk); while (!in_ready);
		sb.note_vertex(x[COORD_W-1:0], y[COORD_W-1:0], last);
	endtask

	// Writes both range registers on back-to-back cycles.
	task automatic write_range(logic [COORD_W-1:0] lo, logic [COORD_W-1:0] hi);
		cfg_we <= 1'b1;
		cfg_index <= REG_MIN_COORD;
		cfg_data <= lo;
		@(posedge clk);
		cfg_index <= REG_MAX_COORD;
		cfg_data <= hi;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_range(REG_MIN_COORD, lo);
		sb.set_range(REG_MAX_COORD, hi);
		range_settings++;
	endtask

	// One polygon: a tight cluster, spread over the range, fully random or at the extremes, sometimes with one random x.
	task automatic send_polygon(int n, int shape);
		int lo, hi, cx, cy, x, y, k, bad;
		lo = sb.lo_mm;
		hi = sb.hi_mm;
		cx = coord_in(lo, hi);
		cy = coord_in(lo, hi);
		bad = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, n - 1)) : -1;
		for (k = 0; k < n; k++) begin
			case (shape)
				0: begin
					x = cx + int'($urandom_range(0, 8)) - 4;
					y = cy + int'($urandom_range(0, 8)) - 4;
				end
				1: begin
					x = coord_in(lo, hi);
					y = coord_in(lo, hi);
				end
				2: begin
					x = $urandom;
					y = $urandom;
				end
				default: begin
					x = extreme(lo, hi);
					y = extreme(lo, hi);
				end
			endcase
			if (k == bad) x = $urandom;
			send_vertex(x, y, k == n - 1);
		end
	endtask

	// Lets every owed status arrive, sets a new range, then streams random polygons.
	task automatic run_phase(int lo, int hi, bit quiet);
		int start;
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_range(lo[COORD_W-1:0], hi[COORD_W-1:0]);
		calm = quiet;
		start = sb.vertices;
		while (sb.vertices - start < PHASE_VERTICES) begin
			send_polygon(pick_count(), $urandom_range(0, 3));
		end
	endtask

	// Checks result transfers, paces out_ready and watches for a stuck block.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) sb.check_result(status, is_valid);
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= WATCH_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, WATCH_LIMIT);
				$display("FAILED: results differ");
				$finish;
			end
			if (out_stall > 0) begin
				out_stall--;
				out_ready <= 1'b0;
			end else begin
				out_stall = pick_gap(RECV_STALL_MAX);
				if (out_stall > 0) begin
					out_stall--;
					out_ready <= 1'b0;
				end else begin
					out_ready <= 1'b1;
				end
			end
		end
	end

	initial begin
		sb = new();
		calm = 1'b0;
		out_stall = 0;
		idle_cycles = 0;
		range_settings = 0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		vertex_x <= '0;
		vertex_y <= '0;
		last_vertex <= 1'b0;
		out_ready <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_MIN_COORD;
		cfg_data <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Too few: a lone vertex, then a pair.
		send_vertex(5, -5, 1'b1);
		send_vertex(-32768, 32767, 1'b0);
		send_vertex(32767, -32768, 1'b1);
		// A triangle spanning the full range is accepted.
		send_vertex(-32768, -32768, 1'b0);
		send_vertex(32767, -32768, 1'b0);
		send_vertex(0, 32767, 1'b1);
		// A bowtie at the extremes crosses; the products need all their bits.
		send_vertex(-32768, -32768, 1'b0);
		send_vertex(32767, 32767, 1'b0);
		send_vertex(32767, -32768, 1'b0);
		send_vertex(-32768, 32767, 1'b1);
		// Edges that only touch along a line are no crossing.
		send_vertex(0, 0, 1'b0);
		send_vertex(2, 0, 1'b0);
		send_vertex(1, 0, 1'b0);
		send_vertex(1, 1, 1'b1);
		// One vertex more than the store holds.
		for (int k = 0; k <= MAXV; k++) begin
			send_vertex(k * 100, (k % 2) * 50, k == MAXV);
		end

		// Range settings: full, narrow and lopsided, single points, inverted, and full with no idle gaps.
		run_phase(-32768, 32767, 1'b0);
		run_phase(-1000, 1000, 1'b0);
		run_phase(0, 0, 1'b0);
		run_phase(32767, -32768, 1'b0);
		run_phase(-32768, 32767, 1'b1);
		run_phase(-5, 20000, 1'b0);
		run_phase(500, 100, 1'b0);
		run_phase(32767, 32767, 1'b0);

		// Drain the last statuses and give the block time to show anything extra.
		in_valid <= 1'b0;
		calm = 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d vertices across %0d range settings and checked %0d polygon statuses.",
			sb.vertices, range_settings + 1, sb.results);
		$display("Statuses seen: ok %0d, too few %0d, too many %0d, out of range %0d, crossing %0d.",
			sb.per_status[0], sb.per_status[1], sb.per_status[2], sb.per_status[3],
			sb.per_status[4]);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
